/* sv/trms_pkg.sv */
package trms_pkg;

    localparam int STEP_W        = 32;
    localparam int HDR_W         = 6;
    localparam int COUNT_W       = 5;
    localparam int TIME_W        = 64;
    localparam int PROD_W        = 26;
    localparam int MS_PER_SECOND = 1000;
    localparam int RELAY_FIELD   = 8;

    typedef enum logic [2:0] {
        K_LOAD_STEP   = 3'd0,
        K_LOAD_HEADER = 3'd1,
        K_START       = 3'd2,
        K_STOP        = 3'd3,
        K_MANUAL      = 3'd4,
        K_TICK        = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        MODE_AUTO = 2'd0,
        MODE_ON   = 2'd1,
        MODE_OFF  = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DUE_START,
        S_ADV_READ,
        S_ADV_APPLY,
        S_ADV_DELAY,
        S_ADV_ADD,
        S_CHECK,
        S_REPORT
    } state_t;

    typedef struct packed {
        logic                   en;
        logic [RELAY_FIELD-1:0] mask;
        logic [1:0]             action;
    } relay_apply_t;

    function automatic logic [1:0] norm_action(input logic [7:0] a);
        logic [1:0] m;
        if (a > 8'(MODE_OFF))
        begin
            m = MODE_AUTO;
        end
        else
        begin
            m = a[1:0];
        end
        return m;
    endfunction

    function automatic logic [PROD_W-1:0] delay_ms(input logic [15:0] d);
        return PROD_W'(d) * PROD_W'(MS_PER_SECOND);
    endfunction

endpackage

/* sv/timed_relay_macro_sequencer_unit.sv */
// Relay macro sequencer. Raise start with a command while busy is low; the
// block then holds busy high until it drives the result for one cycle with
// done high, and that beat must be taken then, since there is no back-pressure.
// Loads, stop, unknown commands, rejected requests and ticks with no timed run
// go from dispatch straight to the report; an accepted start first sets the due
// time, and a manual step reads and applies one step. A tick during a timed run
// executes each step that falls due, at most STEPS_PER_MACRO + 1 steps; steps
// come from the single step memory, which is read once per executed step and
// once more for the delay of the step that follows. Reset needs no clearing pass.
module timed_relay_macro_sequencer_unit import trms_pkg::*; #(
    parameter int MACRO_SLOTS     = 16,
    parameter int STEPS_PER_MACRO = 16,
    parameter int RELAYS          = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [2:0]  kind,
    input  logic [3:0]  macro_slot,
    input  logic [3:0]  step_slot,
    input  logic [15:0] delay_seconds,
    input  logic [7:0]  relay_select,
    input  logic [7:0]  step_action,
    input  logic        slot_used,
    input  logic [4:0]  step_total,
    input  logic        auto_run,
    output logic        busy,
    output logic        done,
    output logic        accepted,
    output logic        running,
    output logic        timed_mode,
    output logic [3:0]  active_slot,
    output logic [4:0]  steps_done,
    output logic [4:0]  steps_in_macro,
    output logic [15:0] relay_modes,
    output logic        modes_changed
);

    localparam int DEPTH = MACRO_SLOTS * STEPS_PER_MACRO;
    localparam int MW    = (MACRO_SLOTS > 1) ? $clog2(MACRO_SLOTS) : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              step_we;
    logic [AW-1:0]     step_waddr;
    logic [STEP_W-1:0] step_wdata;
    logic [AW-1:0]     step_raddr;
    logic [STEP_W-1:0] step_rdata;
    logic              hdr_we;
    logic [MW-1:0]     hdr_waddr;
    logic [HDR_W-1:0]  hdr_wdata;
    logic [MW-1:0]     hdr_raddr;
    logic [HDR_W-1:0]  hdr_rdata;
    relay_apply_t      apply;
    logic              relay_hit;

    trms_step_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_step_ram (
        .clk   (clk),
        .we    (step_we),
        .waddr (step_waddr),
        .wdata (step_wdata),
        .raddr (step_raddr),
        .rdata (step_rdata)
    );

    trms_hdr_ram #(
        .MACRO_SLOTS (MACRO_SLOTS),
        .MW          (MW)
    ) u_hdr_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (hdr_we),
        .waddr (hdr_waddr),
        .wdata (hdr_wdata),
        .raddr (hdr_raddr),
        .rdata (hdr_rdata)
    );

    trms_relay_bank #(
        .RELAYS (RELAYS)
    ) u_relay_bank (
        .clk         (clk),
        .rst_n       (rst_n),
        .apply       (apply),
        .relay_hit   (relay_hit),
        .relay_modes (relay_modes)
    );

    trms_seq #(
        .MACRO_SLOTS     (MACRO_SLOTS),
        .STEPS_PER_MACRO (STEPS_PER_MACRO),
        .MW              (MW),
        .AW              (AW)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .kind           (kind),
        .macro_slot     (macro_slot),
        .step_slot      (step_slot),
        .delay_seconds  (delay_seconds),
        .relay_select   (relay_select),
        .step_action    (step_action),
        .slot_used      (slot_used),
        .step_total     (step_total),
        .auto_run       (auto_run),
        .busy           (busy),
        .done           (done),
        .accepted       (accepted),
        .running        (running),
        .timed_mode     (timed_mode),
        .active_slot    (active_slot),
        .steps_done     (steps_done),
        .steps_in_macro (steps_in_macro),
        .modes_changed  (modes_changed),
        .step_we        (step_we),
        .step_waddr     (step_waddr),
        .step_wdata     (step_wdata),
        .step_raddr     (step_raddr),
        .step_rdata     (step_rdata),
        .hdr_we         (hdr_we),
        .hdr_waddr      (hdr_waddr),
        .hdr_wdata      (hdr_wdata),
        .hdr_raddr      (hdr_raddr),
        .hdr_rdata      (hdr_rdata),
        .apply          (apply),
        .relay_hit      (relay_hit)
    );

endmodule

/* sv/trms_step_ram.sv */
module trms_step_ram import trms_pkg::*; #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [STEP_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [STEP_W-1:0] rdata
);

    logic [STEP_W-1:0] mem [DEPTH];
    logic [STEP_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/trms_hdr_ram.sv */
module trms_hdr_ram import trms_pkg::*; #(
    parameter int MACRO_SLOTS = 16,
    parameter int MW          = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             we,
    input  logic [MW-1:0]    waddr,
    input  logic [HDR_W-1:0] wdata,
    input  logic [MW-1:0]    raddr,
    output logic [HDR_W-1:0] rdata
);

    logic [HDR_W-1:0]       mem [MACRO_SLOTS];
    logic [HDR_W-1:0]       rd_reg;
    logic                   rd_valid_reg;
    logic [MACRO_SLOTS-1:0] valid_reg;
    logic                   raddr_ok;

    assign raddr_ok = int'(raddr) < MACRO_SLOTS;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rd_valid_reg <= raddr_ok && valid_reg[raddr];
        end
    end

    assign rdata = rd_valid_reg ? rd_reg : '0;

endmodule

/* sv/trms_relay_bank.sv */
module trms_relay_bank import trms_pkg::*; #(
    parameter int RELAYS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  relay_apply_t               apply,
    output logic                       relay_hit,
    output logic [2*RELAY_FIELD-1:0]   relay_modes
);

    localparam int RV = (RELAYS < RELAY_FIELD) ? RELAYS : RELAY_FIELD;

    logic [1:0] modes_reg [RV];

    always_comb
    begin
        relay_hit   = 1'b0;
        relay_modes = '0;
        for (int r = 0; r < RV; r++)
        begin
            if (apply.mask[r] && (modes_reg[r] != apply.action))
            begin
                relay_hit = 1'b1;
            end
            relay_modes[2*r +: 2] = modes_reg[r];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < RV; r++)
            begin
                modes_reg[r] <= MODE_AUTO;
            end
        end
        else if (apply.en)
        begin
            for (int r = 0; r < RV; r++)
            begin
                if (apply.mask[r])
                begin
                    modes_reg[r] <= apply.action;
                end
            end
        end
    end

endmodule

/* sv/trms_seq.sv */
module trms_seq import trms_pkg::*; #(
    parameter int MACRO_SLOTS     = 16,
    parameter int STEPS_PER_MACRO = 16,
    parameter int MW              = 4,
    parameter int AW              = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         kind,
    input  logic [3:0]         macro_slot,
    input  logic [3:0]         step_slot,
    input  logic [15:0]        delay_seconds,
    input  logic [7:0]         relay_select,
    input  logic [7:0]         step_action,
    input  logic               slot_used,
    input  logic [4:0]         step_total,
    input  logic               auto_run,
    output logic               busy,
    output logic               done,
    output logic               accepted,
    output logic               running,
    output logic               timed_mode,
    output logic [3:0]         active_slot,
    output logic [4:0]         steps_done,
    output logic [4:0]         steps_in_macro,
    output logic               modes_changed,
    output logic               step_we,
    output logic [AW-1:0]      step_waddr,
    output logic [STEP_W-1:0]  step_wdata,
    output logic [AW-1:0]      step_raddr,
    input  logic [STEP_W-1:0]  step_rdata,
    output logic               hdr_we,
    output logic [MW-1:0]      hdr_waddr,
    output logic [HDR_W-1:0]   hdr_wdata,
    output logic [MW-1:0]      hdr_raddr,
    input  logic [HDR_W-1:0]   hdr_rdata,
    output relay_apply_t       apply,
    input  logic               relay_hit
);

    localparam int GW = $clog2(STEPS_PER_MACRO + 2);

    state_t             state_reg, state_next;
    logic [2:0]         kind_reg;
    logic [3:0]         mslot_reg;
    logic [3:0]         sslot_reg;
    logic [15:0]        delay_reg;
    logic [7:0]         sel_reg;
    logic [7:0]         act_reg;
    logic               used_reg;
    logic [4:0]         total_reg;
    logic               autor_reg;
    logic [PROD_W-1:0]  prod_reg, prod_next;

    logic               run_reg, run_next;
    logic               timed_reg, timed_next;
    logic [3:0]         slot_reg, slot_next;
    logic [4:0]         pend_reg, pend_next;
    logic [4:0]         count_reg, count_next;
    logic [TIME_W-1:0]  due_reg, due_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [GW-1:0]      guard_reg, guard_next;
    logic               acc_reg, acc_next;
    logic               chg_reg, chg_next;

    logic               in_slot_ok;
    logic               mslot_ok;
    logic               sslot_ok;
    logic               hdr_valid;
    logic [4:0]         pend_inc;
    logic [4:0]         sat_total;
    logic               check_go;
    state_t             adv_exit;

    function automatic logic [AW-1:0] step_addr(input logic [3:0] m, input logic [4:0] s);
        int idx;
        idx = int'(m) * STEPS_PER_MACRO + int'(s);
        return AW'(idx);
    endfunction

    assign in_slot_ok = int'(macro_slot) < MACRO_SLOTS;
    assign mslot_ok   = int'(mslot_reg) < MACRO_SLOTS;
    assign sslot_ok   = int'(sslot_reg) < STEPS_PER_MACRO;
    assign hdr_valid  = mslot_ok && hdr_rdata[HDR_W-1] && (hdr_rdata[COUNT_W-1:0] != '0);
    assign pend_inc   = pend_reg + 5'd1;
    assign sat_total  = (int'(total_reg) > STEPS_PER_MACRO) ? 5'(STEPS_PER_MACRO) : total_reg;
    assign check_go   = run_reg && (now_reg >= due_reg)
                        && (int'(guard_reg) < STEPS_PER_MACRO + 1);
    assign adv_exit   = (kind_reg == K_TICK) ? S_CHECK : S_REPORT;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (kind_reg)
                    K_START:  state_next = hdr_valid ? S_DUE_START : S_REPORT;
                    K_MANUAL: state_next = (run_reg || hdr_valid) ? S_ADV_READ : S_REPORT;
                    K_TICK:   state_next = (run_reg && timed_reg) ? S_CHECK : S_REPORT;
                    default:  state_next = S_REPORT;
                endcase
            end
            S_DUE_START: state_next = S_REPORT;
            S_ADV_READ:  state_next = S_ADV_APPLY;
            S_ADV_APPLY: state_next = (pend_inc >= count_reg) ? adv_exit : S_ADV_DELAY;
            S_ADV_DELAY: state_next = S_ADV_ADD;
            S_ADV_ADD:   state_next = adv_exit;
            S_CHECK:     state_next = check_go ? S_ADV_READ : S_REPORT;
            S_REPORT:    state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != S_IDLE);
        done = (state_reg == S_REPORT);
    end

    always_comb
    begin
        run_next   = run_reg;
        timed_next = timed_reg;
        slot_next  = slot_reg;
        pend_next  = pend_reg;
        count_next = count_reg;
        due_next   = due_reg;
        now_next   = now_reg;
        guard_next = guard_reg;
        acc_next   = acc_reg;
        chg_next   = chg_reg;
        prod_next  = prod_reg;
        step_we    = 1'b0;
        step_waddr = step_addr(mslot_reg, 5'(sslot_reg));
        step_wdata = {delay_reg, sel_reg, act_reg};
        step_raddr = '0;
        hdr_we     = 1'b0;
        hdr_waddr  = MW'(mslot_reg);
        hdr_wdata  = {used_reg, sat_total};
        hdr_raddr  = MW'(macro_slot);
        apply      = '0;

        case (state_reg)
            S_IDLE:
            begin
                step_raddr = in_slot_ok ? step_addr(macro_slot, 5'd0) : '0;
                if (start)
                begin
                    acc_next = 1'b0;
                    chg_next = 1'b0;
                end
            end
            S_DISPATCH:
            begin
                unique case (kind_reg)
                    K_LOAD_STEP:
                    begin
                        if (mslot_ok && sslot_ok)
                        begin
                            step_we  = 1'b1;
                            acc_next = 1'b1;
                        end
                    end
                    K_LOAD_HEADER:
                    begin
                        if (mslot_ok)
                        begin
                            hdr_we   = 1'b1;
                            acc_next = 1'b1;
                            if (mslot_reg == slot_reg)
                            begin
                                count_next = sat_total;
                            end
                        end
                    end
                    K_START:
                    begin
                        if (hdr_valid)
                        begin
                            run_next   = 1'b1;
                            slot_next  = mslot_reg;
                            timed_next = autor_reg;
                            pend_next  = '0;
                            count_next = hdr_rdata[COUNT_W-1:0];
                            prod_next  = delay_ms(step_rdata[31:16]);
                            acc_next   = 1'b1;
                        end
                    end
                    K_STOP:
                    begin
                        run_next = 1'b0;
                        acc_next = 1'b1;
                    end
                    K_MANUAL:
                    begin
                        if (run_reg || hdr_valid)
                        begin
                            acc_next   = 1'b1;
                            timed_next = 1'b0;
                            if (!run_reg)
                            begin
                                run_next   = 1'b1;
                                slot_next  = mslot_reg;
                                pend_next  = '0;
                                count_next = hdr_rdata[COUNT_W-1:0];
                                due_next   = now_reg;
                            end
                        end
                    end
                    K_TICK:
                    begin
                        now_next   = now_reg + TIME_W'(1);
                        acc_next   = 1'b1;
                        guard_next = '0;
                    end
                    default:
                    begin
                        acc_next = 1'b0;
                    end
                endcase
            end
            S_DUE_START:
            begin
                due_next = now_reg + TIME_W'(prod_reg);
            end
            S_ADV_READ:
            begin
                step_raddr = (int'(pend_reg) < STEPS_PER_MACRO)
                             ? step_addr(slot_reg, pend_reg) : '0;
            end
            S_ADV_APPLY:
            begin
                if (pend_reg < count_reg)
                begin
                    apply.en     = 1'b1;
                    apply.mask   = step_rdata[15:8];
                    apply.action = norm_action(step_rdata[7:0]);
                    if (relay_hit)
                    begin
                        chg_next = 1'b1;
                    end
                end
                pend_next  = pend_inc;
                step_raddr = (int'(pend_inc) < STEPS_PER_MACRO)
                             ? step_addr(slot_reg, pend_inc) : '0;
                if (pend_inc >= count_reg)
                begin
                    run_next = 1'b0;
                end
            end
            S_ADV_DELAY:
            begin
                prod_next = delay_ms(step_rdata[31:16]);
            end
            S_ADV_ADD:
            begin
                due_next = due_reg + TIME_W'(prod_reg);
            end
            S_CHECK:
            begin
                if (check_go)
                begin
                    guard_next = guard_reg + GW'(1);
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            kind_reg  <= kind;
            mslot_reg <= macro_slot;
            sslot_reg <= step_slot;
            delay_reg <= delay_seconds;
            sel_reg   <= relay_select;
            act_reg   <= step_action;
            used_reg  <= slot_used;
            total_reg <= step_total;
            autor_reg <= auto_run;
        end
        prod_reg <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            run_reg   <= 1'b0;
            timed_reg <= 1'b0;
            slot_reg  <= '0;
            pend_reg  <= '0;
            count_reg <= '0;
            due_reg   <= '0;
            now_reg   <= '0;
            guard_reg <= '0;
            acc_reg   <= 1'b0;
            chg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            run_reg   <= run_next;
            timed_reg <= timed_next;
            slot_reg  <= slot_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            due_reg   <= due_next;
            now_reg   <= now_next;
            guard_reg <= guard_next;
            acc_reg   <= acc_next;
            chg_reg   <= chg_next;
        end
    end

    assign accepted       = acc_reg;
    assign running        = run_reg;
    assign timed_mode     = timed_reg;
    assign active_slot    = run_reg ? slot_reg : '0;
    assign steps_done     = run_reg ? pend_reg : '0;
    assign steps_in_macro = run_reg ? count_reg : '0;
    assign modes_changed  = chg_reg;

    a_guard_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(guard_reg) <= STEPS_PER_MACRO + 1)
        else $error("step guard overran");

    a_time_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (now_reg != $past(now_reg)) |-> $past(state_reg == S_DISPATCH && kind_reg == K_TICK))
        else $error("time advanced outside a tick");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (int'(slot_reg) < MACRO_SLOTS))
        else $error("active slot out of range");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (done && acc_reg && kind_reg == K_START) |-> run_reg)
        else $error("accepted start left the block idle");

endmodule
